### rtl/pairwise_key_slot_table_defines.svh
// assertion macros for the pairwise key slot table
// no dependencies; the macros assume clk_i and rst_ni in the including module
`ifndef PAIRWISE_KEY_SLOT_TABLE_DEFINES_SVH
`define PAIRWISE_KEY_SLOT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PKST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define PKST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PKST_ASSERT(lbl, prop, msg)
`define PKST_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/pkst_pkg.sv
// shared types and constants for the pairwise key slot table
// no dependencies
package pkst_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned ID_W          = 8;
  localparam int unsigned SLOT_W        = 8;
  localparam int unsigned CNT_W         = 5;
  // cell positions compared against the count in this width (depth up to 255)
  localparam int unsigned POS_W         = 8;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 8;

  localparam logic [CNT_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [SLOT_W-1:0] BASE_RESET = 8'd0;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STAT_FOUND     = 3'd0,
    STAT_INSERTED  = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_DELETED   = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_FLUSHED   = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 1'd0,
    CFG_KEY_BASE = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SEARCH,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] dev_idx;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] key_slot;
    logic [CNT_W-1:0]  entry_count;
  } out_beat_t;

  typedef struct packed {
    logic [ID_W-1:0]   dev;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef struct packed {
    logic write;
    logic shift;
  } cell_ctrl_t;

endpackage

### rtl/pkst_cell.sv
// one table cell: holds a device id and key slot, compares and shifts down
// depends on pkst_pkg
module pkst_cell import pkst_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic              live_i,
  input  logic [ID_W-1:0]   req_dev_i,
  input  logic [SLOT_W-1:0] cand_i,
  input  entry_t            next_i,
  output entry_t            entry_o,
  output logic              dev_hit_o,
  output logic              slot_hit_o
);

  entry_t entry_q;

  // append writes the request, delete takes the upper neighbour
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      entry_q <= '{dev: req_dev_i, slot: cand_i};
    end else if (ctrl_i.shift) begin
      entry_q <= next_i;
    end
  end

  // compares only count while the cell is occupied
  assign dev_hit_o  = live_i && (entry_q.dev == req_dev_i);
  assign slot_hit_o = live_i && (entry_q.slot == cand_i);
  assign entry_o    = entry_q;

endmodule

### rtl/pairwise_key_slot_table.sv
// a beat is accepted in idle and matched against the cells; an insert then probes candidate
// slots from the base, stepping over in-use slots, and every result is loaded into the output
// register while the output is not stalled. no new beat is taken until the sequencer is idle.
// reset empties the table and loads capacity 16, base 0; cell contents are not cleared and
// need no clearing pass.
module pairwise_key_slot_table import pkst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "pairwise_key_slot_table_defines.svh"

  fsm_e              state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cap_q;
  logic [SLOT_W-1:0] base_q;
  logic [SLOT_W-1:0] cand_q, cand_d;
  in_beat_t          req_q, req_d;
  out_beat_t         res_q, res_d;
  out_beat_t         out_q;
  logic              out_valid_q, out_valid_d;
  logic              load_out;
  logic              ins, del;
  logic              accept_req;

  entry_t                 cell_entry [TABLE_DEPTH];
  cell_ctrl_t             cell_ctrl  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] dev_hit, slot_hit, live, wr_sel;
  logic                   any_hit, in_use, full;
  logic [SLOT_W-1:0]      hit_slot;
  logic [POS_W-1:0]       eff_cap, count_ext;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CAPACITY: cap_q  <= cfg_data_i[CNT_W-1:0];
        CFG_KEY_BASE: base_q <= cfg_data_i[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective capacity and fill
  assign count_ext = {{(POS_W-CNT_W){1'b0}}, count_q};
  assign eff_cap   = ({{(POS_W-CNT_W){1'b0}}, cap_q} > POS_W'(TABLE_DEPTH)) ?
                     POS_W'(TABLE_DEPTH) : {{(POS_W-CNT_W){1'b0}}, cap_q};
  assign full      = (count_ext >= eff_cap);

  // row of cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t next_entry;
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign next_entry = cell_entry[g];
    end else begin : g_mid
      assign next_entry = cell_entry[g+1];
    end
    assign live[g]           = (count_ext > POS_W'(g));
    assign wr_sel[g]         = (count_ext == POS_W'(g));
    assign cell_ctrl[g].write = ins && wr_sel[g];
    assign cell_ctrl[g].shift = del && (|dev_hit[g:0]);

    pkst_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[g]),
      .live_i     (live[g]),
      .req_dev_i  (req_q.dev_idx),
      .cand_i     (cand_q),
      .next_i     (next_entry),
      .entry_o    (cell_entry[g]),
      .dev_hit_o  (dev_hit[g]),
      .slot_hit_o (slot_hit[g])
    );
  end

  // ids are unique among live cells, so the hit slot is a plain or
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_slot = hit_slot | (cell_entry[i].slot & {SLOT_W{dev_hit[i]}});
    end
  end
  assign any_hit = |dev_hit;
  assign in_use  = |slot_hit;

  // request beat taken for processing
  assign accept_req = (state_q == S_IDLE) && in_valid_i && (in_data_i.mode != MODE_RSVD);

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_data_i.mode != MODE_RSVD)) state_d = S_MATCH;
      end
      S_MATCH: begin
        if ((req_q.mode == MODE_LOOKUP) && !any_hit && !full) state_d = S_SEARCH;
        else state_d = S_DONE;
      end
      S_SEARCH: begin
        if (!in_use) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    count_d  = count_q;
    cand_d   = cand_q;
    req_d    = req_q;
    res_d    = res_q;
    ins      = 1'b0;
    del      = 1'b0;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) req_d = in_data_i;
      end
      S_MATCH: begin
        case (req_q.mode)
          MODE_LOOKUP: begin
            if (any_hit) begin
              res_d = '{status: STAT_FOUND, key_slot: hit_slot, entry_count: count_q};
            end else if (full) begin
              res_d = '{status: STAT_FULL, key_slot: '0, entry_count: count_q};
            end else begin
              cand_d = base_q;
            end
          end
          MODE_DELETE: begin
            if (any_hit) begin
              del     = 1'b1;
              count_d = count_q - 1'b1;
              res_d   = '{status: STAT_DELETED, key_slot: hit_slot, entry_count: count_d};
            end else begin
              res_d = '{status: STAT_NOT_FOUND, key_slot: '0, entry_count: count_q};
            end
          end
          MODE_FLUSH: begin
            count_d = '0;
            res_d   = '{status: STAT_FLUSHED, key_slot: '0, entry_count: '0};
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        if (in_use) begin
          cand_d = cand_q + 1'b1;
        end else begin
          ins     = 1'b1;
          count_d = count_q + 1'b1;
          res_d   = '{status: STAT_INSERTED, key_slot: cand_q, entry_count: count_d};
        end
      end
      S_DONE: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  // output beat register
  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    cand_q <= cand_d;
    res_q  <= res_d;
    if (load_out) out_q <= res_q;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `PKST_ASSERT(a_hit_unique, $onehot0(dev_hit), "device id held by more than one entry")
  `PKST_ASSERT(a_search_room, (state_q == S_SEARCH) |-> !full, "slot search with table full")
  `PKST_NEVER(a_wr_shift, ins && del, "append and shift in the same cycle")
  `PKST_ASSERT(a_accept_match, accept_req |=> (state_q == S_MATCH), "accepted beat not matched")

endmodule
